// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/cict_pkg.sv =====
// ----------------------------------------------------------------------------
// cict_pkg
// Shared types, constants and helpers of the circular interval cut tracker.
// ----------------------------------------------------------------------------
package cict_pkg;

	localparam int MAX_INTERVALS = 16;
	localparam int POINT_BITS    = 32;
	localparam int IDX_W         = $clog2(MAX_INTERVALS);
	localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
	localparam int NUM_W         = 5;
	localparam int MASK_W        = 16;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 1;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [POINT_BITS-1:0] point_t;
	typedef logic [1:0]            req_t;
	typedef logic [NUM_W-1:0]      num_t;
	typedef logic [MASK_W-1:0]     mask_t;

	// Request codes
	localparam req_t REQ_INSERT   = 2'd0;
	localparam req_t REQ_CONTAINS = 2'd1;
	localparam req_t REQ_ARC      = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_INTERVALS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_DIV_MASK  = 1'b1;

	// Write command from the sequencer to the cut table
	typedef struct packed {
		logic   wr_low;
		logic   wr_high;
		logic   clr_empty;
		idx_t   idx;
		point_t data;
	} cut_wr_t;

	// Clamp the programmed interval count into the supported range
	function automatic cnt_t live_count(num_t n);
		if (int'(n) < 2)
			return cnt_t'(2);
		else if (int'(n) > MAX_INTERVALS)
			return cnt_t'(MAX_INTERVALS);
		else
			return cnt_t'(n);
	endfunction

	// Division points past the mask count as bottom
	function automatic logic is_top(mask_t mask, idx_t d);
		if (int'(d) >= MASK_W)
			return 1'b0;
		else
			return mask[d];
	endfunction

endpackage

// ===== rtl/core/cict_cut_mem.sv =====
// ----------------------------------------------------------------------------
// cict_cut_mem
// Per-interval record store: empty flags in flops, low/high cuts in memory
// with one registered read port and one write port.
// ----------------------------------------------------------------------------
module cict_cut_mem (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  cict_pkg::cut_wr_t                      wr,
	input  cict_pkg::idx_t                         rd_idx,
	output logic [cict_pkg::MAX_INTERVALS-1:0]     empty,
	output cict_pkg::point_t                       rd_low,
	output cict_pkg::point_t                       rd_high
);
	import cict_pkg::*;

	logic [MAX_INTERVALS-1:0] empty_q;
	point_t                   low_mem  [MAX_INTERVALS];
	point_t                   high_mem [MAX_INTERVALS];
	point_t                   rd_low_q;
	point_t                   rd_high_q;

	// Empty flags: all set at reset, cleared by the first insert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= '1;
		end else if (wr.clr_empty) begin
			empty_q[wr.idx] <= 1'b0;
		end
	end

	// Cut memories, registered read
	always_ff @(posedge clk) begin
		if (wr.wr_low)
			low_mem[wr.idx] <= wr.data;
		if (wr.wr_high)
			high_mem[wr.idx] <= wr.data;
		rd_low_q  <= low_mem[rd_idx];
		rd_high_q <= high_mem[rd_idx];
	end

	assign empty   = empty_q;
	assign rd_low  = rd_low_q;
	assign rd_high = rd_high_q;

endmodule

// ===== rtl/core/cict_seq.sv =====
// ----------------------------------------------------------------------------
// cict_seq
// Request sequencer: one shared magnitude comparator, reused for every bound
// check, plus a circular walk over the empty flags for arc queries.
// ----------------------------------------------------------------------------
module cict_seq (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  cict_pkg::req_t                     req_type,
	input  cict_pkg::point_t                   point,
	input  cict_pkg::idx_t                     interval_index,
	input  cict_pkg::point_t                   right_point,
	input  cict_pkg::idx_t                     right_index,
	input  logic                               through_top,
	input  cict_pkg::num_t                     num_intervals,
	input  cict_pkg::mask_t                    top_div_mask,
	input  logic [cict_pkg::MAX_INTERVALS-1:0] empty,
	input  cict_pkg::point_t                   rd_low,
	input  cict_pkg::point_t                   rd_high,
	output cict_pkg::idx_t                     rd_idx,
	output cict_pkg::cut_wr_t                  wr,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               answer
);
	import cict_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_L,
		ST_CMP_L,
		ST_CMP_H,
		ST_LOAD_R,
		ST_CMP_R,
		ST_WALK,
		ST_RESP
	} state_t;

	state_t state_q;
	req_t   type_q;
	point_t lp_q;
	point_t rp_q;
	idx_t   li_q;
	idx_t   ri_q;
	logic   want_top_q;
	cnt_t   n_q;
	idx_t   walk_q;
	logic   found_q;
	logic   answer_q;

	point_t cmp_a;
	point_t cmp_b;
	logic   lt;
	logic   li_ok;
	logic   ri_ok;
	logic   empty_l;
	logic   empty_r;
	logic   empty_w;
	logic   top_hit;
	idx_t   li_nxt;
	idx_t   walk_nxt;

	// Shared comparator operand select
	always_comb begin
		cmp_a = lp_q;
		cmp_b = rd_low;
		case (state_q)
			ST_CMP_L: begin
				cmp_a = lp_q;
				cmp_b = (type_q == REQ_ARC) ? rd_high : rd_low;
			end
			ST_CMP_H: begin
				cmp_a = rd_high;
				cmp_b = lp_q;
			end
			ST_CMP_R: begin
				cmp_a = rd_low;
				cmp_b = rp_q;
			end
			default: begin
				cmp_a = lp_q;
				cmp_b = rd_low;
			end
		endcase
	end

	assign lt = (cmp_a < cmp_b);

	// Index checks and circular increments
	assign li_ok    = (cnt_t'(li_q) < n_q);
	assign ri_ok    = (cnt_t'(ri_q) < n_q);
	assign empty_l  = empty[li_q];
	assign empty_r  = empty[ri_q];
	assign empty_w  = empty[walk_q];
	assign top_hit  = (is_top(top_div_mask, walk_q) == want_top_q);
	assign li_nxt   = ((cnt_t'(li_q) + cnt_t'(1)) == n_q) ? '0 : idx_t'(li_q + idx_t'(1));
	assign walk_nxt = ((cnt_t'(walk_q) + cnt_t'(1)) == n_q) ? '0 : idx_t'(walk_q + idx_t'(1));

	// Read address: right end only while fetching it
	assign rd_idx = (state_q == ST_LOAD_R) ? ri_q : li_q;

	// Table writes for inserts
	always_comb begin
		wr           = '0;
		wr.idx       = li_q;
		wr.data      = lp_q;
		if (type_q == REQ_INSERT) begin
			if (state_q == ST_CMP_L && li_ok) begin
				if (empty_l) begin
					wr.wr_low    = 1'b1;
					wr.wr_high   = 1'b1;
					wr.clr_empty = 1'b1;
				end else if (lt) begin
					wr.wr_low = 1'b1;
				end
			end else if (state_q == ST_CMP_H && lt) begin
				wr.wr_high = 1'b1;
			end
		end
	end

	// Sequencer state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			type_q     <= REQ_INSERT;
			lp_q       <= '0;
			rp_q       <= '0;
			li_q       <= '0;
			ri_q       <= '0;
			want_top_q <= 1'b0;
			n_q        <= '0;
			walk_q     <= '0;
			found_q    <= 1'b0;
			answer_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						type_q     <= req_type;
						lp_q       <= point;
						rp_q       <= right_point;
						li_q       <= interval_index;
						ri_q       <= right_index;
						want_top_q <= through_top;
						n_q        <= live_count(num_intervals);
						state_q    <= ST_LOAD_L;
					end
				end
				ST_LOAD_L: begin
					state_q <= ST_CMP_L;
				end
				ST_CMP_L: begin
					case (type_q)
						REQ_INSERT: begin
							if (!li_ok || empty_l || lt) begin
								answer_q <= 1'b0;
								state_q  <= ST_RESP;
							end else begin
								state_q <= ST_CMP_H;
							end
						end
						REQ_CONTAINS: begin
							if (!li_ok) begin
								answer_q <= 1'b0;
								state_q  <= ST_RESP;
							end else if (empty_l || lt) begin
								answer_q <= 1'b1;
								state_q  <= ST_RESP;
							end else begin
								state_q <= ST_CMP_H;
							end
						end
						REQ_ARC: begin
							if (!li_ok || !ri_ok || (li_q == ri_q) || (!empty_l && lt)) begin
								answer_q <= 1'b0;
								state_q  <= ST_RESP;
							end else begin
								state_q <= ST_LOAD_R;
							end
						end
						default: begin
							answer_q <= 1'b0;
							state_q  <= ST_RESP;
						end
					endcase
				end
				ST_CMP_H: begin
					answer_q <= (type_q == REQ_CONTAINS) && lt;
					state_q  <= ST_RESP;
				end
				ST_LOAD_R: begin
					state_q <= ST_CMP_R;
				end
				ST_CMP_R: begin
					if (!empty_r && lt) begin
						answer_q <= 1'b0;
						state_q  <= ST_RESP;
					end else begin
						walk_q  <= li_nxt;
						found_q <= 1'b0;
						state_q <= ST_WALK;
					end
				end
				// One interval per cycle: inner ones must be empty; every
				// crossed division point is checked for the wanted kind
				ST_WALK: begin
					if (walk_q == ri_q) begin
						answer_q <= found_q | top_hit;
						state_q  <= ST_RESP;
					end else if (!empty_w) begin
						answer_q <= 1'b0;
						state_q  <= ST_RESP;
					end else begin
						found_q <= found_q | top_hit;
						walk_q  <= walk_nxt;
					end
				end
				ST_RESP: begin
					if (!out_stall)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_RESP);
	assign answer    = answer_q;

endmodule

// ===== rtl/core/circular_interval_cut_tracker_top.sv =====
// ----------------------------------------------------------------------------
// circular_interval_cut_tracker_top
// Per-interval cut bounds on a circle with insert, contains and arc queries.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | req_type, point, interval_index,
//          |           |                      | right_point, right_index, through_top
//  out     | output    | out_valid/ out_stall | answer
//  cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
//  One transaction at a time; the sequencer and its single comparator set the pace.
//  Insert and contains load the left record, compare its low and, if needed, its high
//  cut; arc queries also load and compare the right record, then walk one interval per walk cycle.
//  The next transaction can be taken in the cycle after the result is taken.
//  Reset empties every interval; num_intervals returns to 16, top_div_mask to 0.
//  in_stall stays high from accept until the result transaction completes.
// ----------------------------------------------------------------------------
module circular_interval_cut_tracker_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  cict_pkg::req_t                     req_type,
	input  cict_pkg::point_t                   point,
	input  cict_pkg::idx_t                     interval_index,
	input  cict_pkg::point_t                   right_point,
	input  cict_pkg::idx_t                     right_index,
	input  logic                               through_top,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               answer,
	input  logic                               cfg_we,
	input  logic [cict_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cict_pkg::CFG_W-1:0]         cfg_data
);
	import cict_pkg::*;

	num_t                     num_intervals_q;
	mask_t                    top_div_mask_q;
	logic [MAX_INTERVALS-1:0] empty;
	point_t                   rd_low;
	point_t                   rd_high;
	idx_t                     rd_idx;
	cut_wr_t                  wr;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_intervals_q <= num_t'(16);
			top_div_mask_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_INTERVALS: num_intervals_q <= cfg_data[NUM_W-1:0];
				CFG_TOP_DIV_MASK:  top_div_mask_q  <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// Record store
	cict_cut_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_idx  (rd_idx),
		.empty   (empty),
		.rd_low  (rd_low),
		.rd_high (rd_high)
	);

	// Sequencer
	cict_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.point          (point),
		.interval_index (interval_index),
		.right_point    (right_point),
		.right_index    (right_index),
		.through_top    (through_top),
		.num_intervals  (num_intervals_q),
		.top_div_mask   (top_div_mask_q),
		.empty          (empty),
		.rd_low         (rd_low),
		.rd_high        (rd_high),
		.rd_idx         (rd_idx),
		.wr             (wr),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.answer         (answer)
	);

endmodule

// ===== rtl/core/cict_checker.sv =====
// ----------------------------------------------------------------------------
// cict_checker
// Port-level checks of the tracker's handshake behavior, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cict_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic answer
);

	// Stalled result holds its value
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(answer))
	// Busy right after an accepted transaction
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// No new transaction while a result is pending
	`ASSERT_NOW(a_no_accept_pending, clk, arst_n, out_valid, in_stall)
	// Exactly one result per transaction: output drops after delivery
	`ASSERT_NEXT(a_single_result, clk, arst_n, out_valid && !out_stall, !out_valid)

endmodule

bind circular_interval_cut_tracker_top cict_checker u_cict_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.answer    (answer)
);
